@@ design/pgct_pkg.sv @@
// ----------------------------------------------------------------------------
// pgct_pkg - paging group call tracker shared definitions
// Table sizes, derived widths, stream layout and the codes used by the
// tracker: operations, result kinds and sequencer states.
// ----------------------------------------------------------------------------
package pgct_pkg;

  // table geometry
  localparam int NUM_GROUPS  = 16;
  localparam int MAX_MEMBERS = 32;

  localparam int GRP_W       = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int CNT_W       = $clog2(MAX_MEMBERS + 1);
  localparam int STORE_DEPTH = NUM_GROUPS * MAX_MEMBERS;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  // field widths
  localparam int CAP_W   = 32;
  localparam int VEC_W   = 32;
  localparam int CYC_W   = 4;
  localparam int FRAME_W = 7;
  localparam int GNUM_W  = 7;
  localparam int GOUT_W  = 4;

  // vector word layout
  localparam int VEC_GRP_LSB   = 17;
  localparam int VEC_FRAME_LSB = 10;

  // last cycle number before wrap
  localparam logic [CYC_W-1:0] CYC_LAST = 4'd15;

  // stream widths, padded to whole bytes
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [1:0] {
    OP_REGISTER = 2'd0,
    OP_DELIVER  = 2'd1,
    OP_EXPIRE   = 2'd2,
    OP_UNUSED   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_MEMBER = 2'd1,
    KIND_MISSED = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REG,
    ST_DLV_CHK,
    ST_DLV_RD,
    ST_DLV_EMIT,
    ST_EXP_SCAN,
    ST_EXP_FLUSH,
    ST_NONE
  } state_t;

endpackage

@@ design/pager_group_call_tracker.sv @@
// ----------------------------------------------------------------------------
// pager_group_call_tracker - paging group membership table
// Registers capcodes into paging groups, delivers a group's members and
// expires groups whose due frame and cycle have passed.
// ----------------------------------------------------------------------------
// One word is worked on at a time; in_tready is high only while the
// sequencer is idle. A register word passes through ST_REG. A deliver word
// passes through ST_DLV_CHK, then ST_DLV_RD and ST_DLV_EMIT once per member
// (one member store read, then the emit); the single member store read port
// sets this. A deliver of an empty or unknown group, or a word with an unused
// operation, goes to ST_NONE. An expire word walks ST_EXP_SCAN, where one
// shared compare unit checks one group per cycle unless an expired group waits
// on a held output register, then ST_EXP_FLUSH. Any state that loads the
// output register waits while the sink still holds it. The member store needs
// no clearing pass: entries are read only below a group's count.
module pager_group_call_tracker (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: capcode[31:0], vector_info[63:32], cycle_now[67:64],
  //           frame_now[74:68], group_sel[81:75], zero pad[87:82]
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [pgct_pkg::IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: operation[1:0]
  input  logic [1:0]                       in_tuser,
  // out_tdata: ok[0], group_out[4:1], member[36:5], zero pad[39:37]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [pgct_pkg::OUT_TDATA_W-1:0] out_tdata,
  // out_tuser: kind[1:0]
  output logic [1:0]                       out_tuser,
  output logic                             out_tlast
);

  localparam int GRP_W  = pgct_pkg::GRP_W;
  localparam int CNT_W  = pgct_pkg::CNT_W;
  localparam int ADDR_W = pgct_pkg::ADDR_W;

  // sequencer
  pgct_pkg::state_t state_r, state_nxt;

  // latched input word
  pgct_pkg::op_t                  op_r;
  logic [pgct_pkg::CAP_W-1:0]     cap_r;
  logic [pgct_pkg::VEC_W-1:0]     vec_r;
  logic [pgct_pkg::CYC_W-1:0]     cyc_r;
  logic [pgct_pkg::FRAME_W-1:0]   frm_r;
  logic [pgct_pkg::GNUM_W-1:0]    sel_r;

  // group table
  logic [CNT_W-1:0]               member_count_r [pgct_pkg::NUM_GROUPS];
  logic [pgct_pkg::FRAME_W-1:0]   due_frame_r    [pgct_pkg::NUM_GROUPS];
  logic [pgct_pkg::CYC_W-1:0]     due_cycle_r    [pgct_pkg::NUM_GROUPS];

  // member store
  logic [pgct_pkg::CAP_W-1:0]     member_store [pgct_pkg::STORE_DEPTH];
  logic [pgct_pkg::CAP_W-1:0]     mem_q_r;
  logic [ADDR_W-1:0]              mem_raddr;
  logic [ADDR_W-1:0]              mem_waddr;
  logic                           mem_we;

  // walk counters and pending expired group
  logic [CNT_W-1:0]               idx_r, idx_nxt;
  logic [GRP_W-1:0]               scan_r, scan_nxt;
  logic                           pend_v_r, pend_v_nxt;
  logic [GRP_W-1:0]               pend_grp_r, pend_grp_nxt;

  // output register
  logic                           out_valid_r;
  pgct_pkg::kind_t                out_kind_r;
  logic                           out_ok_r;
  logic [pgct_pkg::GOUT_W-1:0]    out_grp_r;
  logic [pgct_pkg::CAP_W-1:0]     out_member_r;
  logic                           out_last_r;

  logic                           out_load;
  pgct_pkg::kind_t                ld_kind;
  logic                           ld_ok;
  logic [pgct_pkg::GNUM_W-1:0]    ld_grp;
  logic [pgct_pkg::CAP_W-1:0]     ld_member;
  logic                           ld_last;

  // table update controls
  logic                           cnt_inc;
  logic                           cnt_clr;
  logic [GRP_W-1:0]               cnt_clr_idx;

  // shared conditions
  logic                           in_acc;
  logic                           out_free;
  logic [pgct_pkg::GNUM_W-1:0]    reg_grp;
  logic [pgct_pkg::FRAME_W-1:0]   reg_frame;
  logic [GRP_W-1:0]               reg_gi;
  logic                           reg_ok;
  logic [pgct_pkg::CYC_W-1:0]     reg_due_cyc;
  logic [GRP_W-1:0]               sel_gi;
  logic [CNT_W-1:0]               dlv_cnt;
  logic                           dlv_bad;
  logic                           dlv_last;
  logic                           scan_hit;
  logic                           scan_end;
  logic                           scan_stall;

  // due time compare, with wrap of the cycle number
  function automatic logic overdue(input logic [pgct_pkg::CYC_W-1:0]   tc,
                                   input logic [pgct_pkg::FRAME_W-1:0] tf,
                                   input logic [pgct_pkg::CYC_W-1:0]   cyc,
                                   input logic [pgct_pkg::FRAME_W-1:0] frm);
    logic res;
    if (cyc == tc) begin
      res = (tf < frm);
    end else if (cyc == '0) begin
      res = (tc == pgct_pkg::CYC_LAST);
    end else if (cyc == pgct_pkg::CYC_LAST && tc == '0) begin
      res = 1'b0;
    end else begin
      res = (tc < cyc);
    end
    return res;
  endfunction

  assign in_tready = (state_r == pgct_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // register word decode
  assign reg_grp     = vec_r[pgct_pkg::VEC_GRP_LSB +: pgct_pkg::GNUM_W];
  assign reg_frame   = vec_r[pgct_pkg::VEC_FRAME_LSB +: pgct_pkg::FRAME_W];
  assign reg_gi      = reg_grp[GRP_W-1:0];
  assign reg_ok      = (reg_grp < pgct_pkg::GNUM_W'(pgct_pkg::NUM_GROUPS)) &&
                       (member_count_r[reg_gi] < CNT_W'(pgct_pkg::MAX_MEMBERS));
  assign reg_due_cyc = (reg_frame > frm_r) ? cyc_r : cyc_r + pgct_pkg::CYC_W'(1);

  // deliver walk
  assign sel_gi   = sel_r[GRP_W-1:0];
  assign dlv_bad  = !(sel_r < pgct_pkg::GNUM_W'(pgct_pkg::NUM_GROUPS)) ||
                    (member_count_r[sel_gi] == '0);
  assign dlv_cnt  = member_count_r[sel_gi];
  assign dlv_last = ((idx_r + CNT_W'(1)) == dlv_cnt);

  // expire scan, one group per cycle while not stalled by the output
  assign scan_hit   = (member_count_r[scan_r] != '0) &&
                      overdue(due_cycle_r[scan_r], due_frame_r[scan_r], cyc_r, frm_r);
  assign scan_end   = (scan_r == GRP_W'(pgct_pkg::NUM_GROUPS - 1));
  assign scan_stall = scan_hit && pend_v_r && !out_free;

  // store addresses
  assign mem_raddr = ADDR_W'(sel_gi) * ADDR_W'(pgct_pkg::MAX_MEMBERS) + ADDR_W'(idx_r);
  assign mem_waddr = ADDR_W'(reg_gi) * ADDR_W'(pgct_pkg::MAX_MEMBERS) +
                     ADDR_W'(member_count_r[reg_gi]);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pgct_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          case (pgct_pkg::op_t'(in_tuser))
            pgct_pkg::OP_REGISTER: state_nxt = pgct_pkg::ST_REG;
            pgct_pkg::OP_DELIVER:  state_nxt = pgct_pkg::ST_DLV_CHK;
            pgct_pkg::OP_EXPIRE:   state_nxt = pgct_pkg::ST_EXP_SCAN;
            default:               state_nxt = pgct_pkg::ST_NONE;
          endcase
        end
      end
      pgct_pkg::ST_REG: begin
        if (out_free) state_nxt = pgct_pkg::ST_IDLE;
      end
      pgct_pkg::ST_DLV_CHK: begin
        state_nxt = dlv_bad ? pgct_pkg::ST_NONE : pgct_pkg::ST_DLV_RD;
      end
      pgct_pkg::ST_DLV_RD: begin
        state_nxt = pgct_pkg::ST_DLV_EMIT;
      end
      pgct_pkg::ST_DLV_EMIT: begin
        if (out_free) state_nxt = dlv_last ? pgct_pkg::ST_IDLE : pgct_pkg::ST_DLV_RD;
      end
      pgct_pkg::ST_EXP_SCAN: begin
        if (!scan_stall && scan_end) state_nxt = pgct_pkg::ST_EXP_FLUSH;
      end
      pgct_pkg::ST_EXP_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = pgct_pkg::ST_NONE;
        end else if (out_free) begin
          state_nxt = pgct_pkg::ST_IDLE;
        end
      end
      pgct_pkg::ST_NONE: begin
        if (out_free) state_nxt = pgct_pkg::ST_IDLE;
      end
      default: state_nxt = pgct_pkg::ST_IDLE;
    endcase
  end

  // datapath controls and result words
  always_comb begin
    out_load     = 1'b0;
    ld_kind      = pgct_pkg::KIND_NONE;
    ld_ok        = 1'b0;
    ld_grp       = '0;
    ld_member    = '0;
    ld_last      = 1'b1;
    mem_we       = 1'b0;
    cnt_inc      = 1'b0;
    cnt_clr      = 1'b0;
    cnt_clr_idx  = sel_gi;
    idx_nxt      = idx_r;
    scan_nxt     = scan_r;
    pend_v_nxt   = pend_v_r;
    pend_grp_nxt = pend_grp_r;
    case (state_r)
      pgct_pkg::ST_IDLE: begin
        idx_nxt    = '0;
        scan_nxt   = '0;
        pend_v_nxt = 1'b0;
      end
      pgct_pkg::ST_REG: begin
        if (out_free) begin
          out_load = 1'b1;
          ld_kind  = pgct_pkg::KIND_STATUS;
          ld_ok    = reg_ok;
          ld_grp   = reg_grp;
          mem_we   = reg_ok;
          cnt_inc  = reg_ok;
        end
      end
      pgct_pkg::ST_DLV_EMIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          ld_kind   = pgct_pkg::KIND_MEMBER;
          ld_ok     = 1'b1;
          ld_grp    = sel_r;
          ld_member = mem_q_r;
          ld_last   = dlv_last;
          cnt_clr   = dlv_last;
          idx_nxt   = idx_r + CNT_W'(1);
        end
      end
      pgct_pkg::ST_EXP_SCAN: begin
        if (!scan_stall) begin
          if (scan_hit) begin
            cnt_clr      = 1'b1;
            cnt_clr_idx  = scan_r;
            pend_v_nxt   = 1'b1;
            pend_grp_nxt = scan_r;
            // an earlier hit is not the last one
            if (pend_v_r) begin
              out_load = 1'b1;
              ld_kind  = pgct_pkg::KIND_MISSED;
              ld_ok    = 1'b1;
              ld_grp   = pgct_pkg::GNUM_W'(pend_grp_r);
              ld_last  = 1'b0;
            end
          end
          if (!scan_end) scan_nxt = scan_r + GRP_W'(1);
        end
      end
      pgct_pkg::ST_EXP_FLUSH: begin
        if (pend_v_r && out_free) begin
          out_load   = 1'b1;
          ld_kind    = pgct_pkg::KIND_MISSED;
          ld_ok      = 1'b1;
          ld_grp     = pgct_pkg::GNUM_W'(pend_grp_r);
          pend_v_nxt = 1'b0;
        end
      end
      pgct_pkg::ST_NONE: begin
        if (out_free) begin
          out_load = 1'b1;
          ld_grp   = (op_r == pgct_pkg::OP_DELIVER) ? sel_r : '0;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pgct_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
      for (int g = 0; g < pgct_pkg::NUM_GROUPS; g++) begin
        member_count_r[g] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      pend_v_r <= pend_v_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cnt_inc) begin
        member_count_r[reg_gi] <= member_count_r[reg_gi] + CNT_W'(1);
      end else if (cnt_clr) begin
        member_count_r[cnt_clr_idx] <= '0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    scan_r     <= scan_nxt;
    pend_grp_r <= pend_grp_nxt;
    if (in_acc) begin
      op_r  <= pgct_pkg::op_t'(in_tuser);
      cap_r <= in_tdata[31:0];
      vec_r <= in_tdata[63:32];
      cyc_r <= in_tdata[67:64];
      frm_r <= in_tdata[74:68];
      sel_r <= in_tdata[81:75];
    end
    if (cnt_inc) begin
      due_frame_r[reg_gi] <= reg_frame;
      due_cycle_r[reg_gi] <= reg_due_cyc;
    end
    if (out_load) begin
      out_kind_r   <= ld_kind;
      out_ok_r     <= ld_ok;
      out_grp_r    <= ld_grp[pgct_pkg::GOUT_W-1:0];
      out_member_r <= ld_member;
      out_last_r   <= ld_last;
    end
  end

  // member store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      member_store[mem_waddr] <= cap_r;
    end
    mem_q_r <= member_store[mem_raddr];
  end

  // output stream
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {3'b000, out_member_r, out_grp_r, out_ok_r};

endmodule
